// ===== design/gglo_pkg.sv =====
`timescale 1ns / 1ps
package gglo_pkg;

  localparam int unsigned DEF_ANGLE_FRAC_BITS = 30;
  localparam int unsigned DEF_CORDIC_STAGES   = 32;

  // Width of a degree difference (1e-7 deg units), sign included.
  localparam int unsigned DIFF_W = 34;

  localparam logic [63:0] DEG_RAD_Q64    = 64'd32195642036;
  localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] KINV_Q62       = 64'd2800459870029452956;
  localparam logic [40:0] R_MM_Q8        = 41'd1631436175578;

  localparam int unsigned IN_W  = 128;
  localparam int unsigned OUT_W = 112;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FACING_NORTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVAL_RADIUS = 8'd1;
  localparam logic [19:0]          ARRIVAL_RADIUS_RST = 20'd2000;

  // Sideband that rides along the pipeline with each item.
  typedef struct packed {
    logic vld;
    logic neg_e;
    logic neg_n;
  } side_t;

  // Elaboration-time shift/subtract division.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q62: pi/4 for i = 0, else by its power series.
  function automatic logic [63:0] atan_q62(int unsigned i);
    logic [63:0] v;
    logic [63:0] term;
    int unsigned e;
    v = '0;
    if (i == 0) begin
      v = PI_QUARTER_Q62;
    end else begin
      for (int unsigned n = 0; n < 32; n++) begin
        e = i * (2 * n + 1);
        if (e <= 62) begin
          term = udiv64(64'd1 << (62 - e), 64'(2 * n + 1));
          if (n[0]) v = v - term;
          else      v = v + term;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] q62_to_f(logic [63:0] v, int unsigned f);
    int unsigned sh;
    sh = 62 - f;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== design/gps_goal_local_offset.sv =====
`timescale 1ns / 1ps
// GPS goal offset. Takes robot and goal fixes (1e-7 degree, two's complement)
// and returns the east and north offsets of the goal, the great-circle
// distance (all in mm, sphere of radius 6372797.56085 m, haversine) and a
// flag that is set when the distance is below the arrival radius. One item
// is accepted every clock while the output is not stalled. The pipeline is
// the rotation CORDIC, one square-root bit per stage and the vectoring
// CORDIC, all fully unrolled. A stalled output holds the whole pipeline;
// nothing is dropped or repeated. Config: index 0 facing_north (bit 0; 0
// negates both offsets), index 1 arrival_radius_mm (20 bits, reset 2000);
// other indexes are ignored. Write config only while no item is in flight.
module gps_goal_local_offset #(
  parameter int unsigned ANGLE_FRAC_BITS = gglo_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned CORDIC_STAGES   = gglo_pkg::DEF_CORDIC_STAGES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: robot_lat[30:0], robot_lon[62:31], goal_lat[93:63],
  //        goal_lon[125:94], zero fill
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gglo_pkg::IN_W-1:0]         s_axis_tdata,
  // tdata: east_offset_mm[35:0], north_offset_mm[71:36],
  //        distance_mm[106:72], goal_reached[107], zero fill
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gglo_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gglo_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gglo_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gglo_pkg::*;

  localparam int unsigned F   = ANGLE_FRAC_BITS;
  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned LAT = (3 + N) + 2 + (3 + (F + 1) + N + 2);
  localparam logic [F:0]  ONE = (F+1)'(1) << F;

  // ---- config registers ----
  logic        fn_q;
  logic [19:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_q     <= 1'b0;
      radius_q <= ARRIVAL_RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FACING_NORTH:   fn_q     <= cfg_data_i[0];
        CFG_ARRIVAL_RADIUS: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- global advance: whole pipe moves unless output is stuck ----
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [30:0] rlat, glat;
  logic signed [31:0] rlon, glon;
  assign rlat = s_axis_tdata[30:0];
  assign rlon = s_axis_tdata[62:31];
  assign glat = s_axis_tdata[93:63];
  assign glon = s_axis_tdata[125:94];

  logic signed [DIFF_W-1:0] d_dlat, d_dlon, d_rlat, d_glat;
  assign d_dlat = DIFF_W'(glat) - DIFF_W'(rlat);
  assign d_dlon = DIFF_W'(glon) - DIFF_W'(rlon);
  assign d_rlat = DIFF_W'(rlat);
  assign d_glat = DIFF_W'(glat);

  // ---- valid and sign sideband, aligned with the arc outputs ----
  side_t side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) side_q[s] <= '0;
    end else if (en) begin
      side_q[0].vld   <= s_axis_tvalid;
      side_q[0].neg_e <= rlon > glon;
      side_q[0].neg_n <= rlat > glat;
      for (int s = 1; s < LAT; s++) side_q[s] <= side_q[s-1];
    end
  end

  // ---- four sin/cos lanes ----
  logic signed [F+2:0] sdlat, sdlon, crl, cgl;
  logic signed [F+2:0] unused_c0, unused_c1, unused_s0, unused_s1;

  gglo_rot #(.F(F), .N(N), .HALF(1'b1)) u_rot_dlat (
    .clk_i, .en_i(en), .d_i(d_dlat), .sin_o(sdlat), .cos_o(unused_c0));
  gglo_rot #(.F(F), .N(N), .HALF(1'b1)) u_rot_dlon (
    .clk_i, .en_i(en), .d_i(d_dlon), .sin_o(sdlon), .cos_o(unused_c1));
  gglo_rot #(.F(F), .N(N), .HALF(1'b0)) u_rot_rlat (
    .clk_i, .en_i(en), .d_i(d_rlat), .sin_o(unused_s0), .cos_o(crl));
  gglo_rot #(.F(F), .N(N), .HALF(1'b0)) u_rot_glat (
    .clk_i, .en_i(en), .d_i(d_glat), .sin_o(unused_s1), .cos_o(cgl));

  // ---- magnitudes, cosine clamp, cosine products ----
  logic [F+1:0]   sa_lat_q, sa_lon_q, sb_lat_q, sb_lon_q;
  logic [F:0]     cr_q, cg_q, ke_q, kf_q;
  logic [F:0]     cr_c, cg_c;
  logic [2*F+2:0] ke_p, kf_p;

  always_comb begin
    cr_c = crl[F+2] ? '0 : ((crl > $signed({2'b00, ONE})) ? ONE : (F+1)'(crl));
    cg_c = cgl[F+2] ? '0 : ((cgl > $signed({2'b00, ONE})) ? ONE : (F+1)'(cgl));
    ke_p = ((2*F+3)'(cr_q) * (2*F+3)'(cr_q) + ((2*F+3)'(1) << (F - 1))) >> F;
    kf_p = ((2*F+3)'(cr_q) * (2*F+3)'(cg_q) + ((2*F+3)'(1) << (F - 1))) >> F;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_lat_q <= sdlat[F+2] ? (F+2)'(-sdlat) : (F+2)'(sdlat);
      sa_lon_q <= sdlon[F+2] ? (F+2)'(-sdlon) : (F+2)'(sdlon);
      cr_q     <= cr_c;
      cg_q     <= cg_c;
      sb_lat_q <= sa_lat_q;
      sb_lon_q <= sa_lon_q;
      ke_q     <= (F+1)'(ke_p);
      kf_q     <= (F+1)'(kf_p);
    end
  end

  // ---- three arcs: east, north, full ----
  logic [34:0] east_mm, north_mm, dist_mm;

  gglo_arc #(.F(F), .N(N)) u_arc_east (
    .clk_i, .en_i(en), .s1_i('0), .k_i(ke_q), .s2_i(sb_lon_q), .dist_o(east_mm));
  gglo_arc #(.F(F), .N(N)) u_arc_north (
    .clk_i, .en_i(en), .s1_i(sb_lat_q), .k_i('0), .s2_i('0), .dist_o(north_mm));
  gglo_arc #(.F(F), .N(N)) u_arc_full (
    .clk_i, .en_i(en), .s1_i(sb_lat_q), .k_i(kf_q), .s2_i(sb_lon_q), .dist_o(dist_mm));

  // ---- signs, arrival test, output register ----
  logic        ne, nn;
  logic [35:0] east_s, north_s;
  assign ne      = side_q[LAT-1].neg_e ^ !fn_q;
  assign nn      = side_q[LAT-1].neg_n ^ !fn_q;
  assign east_s  = ne ? -(36'(east_mm)) : 36'(east_mm);
  assign north_s = nn ? -(36'(north_mm)) : 36'(north_mm);

  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= side_q[LAT-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {4'b0000, (dist_mm < 35'(radius_q)), dist_mm, north_s, east_s};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/gglo_rot.sv =====
`timescale 1ns / 1ps
// Angle reduction, degree->radian scaling and rotation CORDIC for one angle.
module gglo_rot #(
  parameter int unsigned F    = gglo_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned N    = gglo_pkg::DEF_CORDIC_STAGES,
  parameter bit          HALF = 1'b0
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [gglo_pkg::DIFF_W-1:0] d_i,
  output logic signed [F+2:0]               sin_o,
  output logic signed [F+2:0]               cos_o
);
  import gglo_pkg::*;

  localparam int unsigned W  = F + 3;
  localparam int unsigned SH = 64 - F + (HALF ? 1 : 0);
  localparam logic signed [35:0] HT = HALF ? 36'sd3600000000 : 36'sd1800000000;
  localparam logic signed [35:0] QT = HT >>> 1;
  localparam logic signed [W-1:0] KINV_F = W'(q62_to_f(KINV_Q62, F));

  logic signed [35:0] dext, dw, df;
  logic               flip_c, neg_c;
  logic [30:0]        mag_c;

  // wrap into one turn, fold into a quarter each side
  always_comb begin
    dext = 36'(d_i);
    dw   = dext;
    if (dext >= HT) begin
      dw = dext - (HT <<< 1);
    end else if (dext < -HT) begin
      dw = dext + (HT <<< 1);
    end
    df     = dw;
    flip_c = 1'b0;
    if (dw > QT) begin
      df     = HT - dw;
      flip_c = 1'b1;
    end else if (dw < -QT) begin
      df     = -HT - dw;
      flip_c = 1'b1;
    end
    neg_c = df[35];
    mag_c = neg_c ? 31'(-df) : 31'(df);
  end

  logic [30:0] mag_q;
  logic        neg1_q, flip1_q, neg2_q, flip2_q;
  logic [48:0] pl_q;
  logic [47:0] ph_q;
  logic [67:0] prod;
  logic signed [W-1:0] zs, z0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_c;
      neg1_q  <= neg_c;
      flip1_q <= flip_c;
      pl_q    <= 49'(mag_q) * 49'(DEG_RAD_Q64[17:0]);
      ph_q    <= 48'(mag_q) * 48'(DEG_RAD_Q64[34:18]);
      neg2_q  <= neg1_q;
      flip2_q <= flip1_q;
    end
  end

  always_comb begin
    prod = 68'(pl_q) + (68'(ph_q) << 18) + (68'd1 << (SH - 1));
    zs   = W'(prod >> SH);
    z0   = neg2_q ? -zs : zs;
  end

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                fl_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= KINV_F;
      y_q[0]  <= '0;
      z_q[0]  <= z0;
      fl_q[0] <= flip2_q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [W-1:0] ATAN = W'(q62_to_f(atan_q62(i), F));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ATAN;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ATAN;
        end
        fl_q[i+1] <= fl_q[i];
      end
    end
  end

  assign sin_o = y_q[N];
  assign cos_o = fl_q[N] ? -x_q[N] : x_q[N];

endmodule

// ===== design/gglo_arc.sv =====
`timescale 1ns / 1ps
// Haversine term, two square roots, vectoring CORDIC and scaling to mm.
module gglo_arc #(
  parameter int unsigned F = gglo_pkg::DEF_ANGLE_FRAC_BITS,
  parameter int unsigned N = gglo_pkg::DEF_CORDIC_STAGES
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [F+1:0]   s1_i,
  input  logic [F:0]     k_i,
  input  logic [F+1:0]   s2_i,
  output logic [34:0]    dist_o
);
  import gglo_pkg::*;

  localparam int unsigned PW    = 2 * F + 4;
  localparam int unsigned SQ_W  = 2 * F + 2;
  localparam int unsigned REM_W = F + 4;
  localparam int unsigned VW    = F + 4;
  localparam logic [PW:0] ONE   = (PW+1)'(1) << (2 * F);

  logic [F+1:0]  t_q, s2_q;
  logic [PW-1:0] a1_q, a2_q, b_q;
  logic [PW-1:0] tp;
  logic [PW:0]   sum, a3;

  always_comb begin
    tp  = (PW'(k_i) * PW'(s2_i) + (PW'(1) << (F - 1))) >> F;
    sum = (PW+1)'(a2_q) + (PW+1)'(b_q);
    a3  = (sum > ONE) ? ONE : sum;
  end

  logic [SQ_W-1:0]  sv_q   [F+2][2];
  logic [REM_W-1:0] srem_q [F+2][2];
  logic [F:0]       sr_q   [F+2][2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= (F+2)'(tp);
      s2_q <= s2_i;
      a1_q <= PW'(s1_i) * PW'(s1_i);
      b_q  <= PW'(t_q) * PW'(s2_q);
      a2_q <= a1_q;
      sv_q[0][0]   <= SQ_W'(a3);
      sv_q[0][1]   <= SQ_W'(ONE - a3);
      srem_q[0][0] <= '0;
      srem_q[0][1] <= '0;
      sr_q[0][0]   <= '0;
      sr_q[0][1]   <= '0;
    end
  end

  // one root bit per stage, both roots side by side
  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    logic [REM_W-1:0] rn [2];
    logic [REM_W-1:0] tr [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rn[l] = {srem_q[j][l][REM_W-3:0], sv_q[j][l][SQ_W-1 -: 2]};
        tr[l] = REM_W'({sr_q[j][l], 2'b01});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 2; l++) begin
          sv_q[j+1][l] <= sv_q[j][l] << 2;
          if (rn[l] >= tr[l]) begin
            srem_q[j+1][l] <= rn[l] - tr[l];
            sr_q[j+1][l]   <= {sr_q[j][l][F-1:0], 1'b1};
          end else begin
            srem_q[j+1][l] <= rn[l];
            sr_q[j+1][l]   <= {sr_q[j][l][F-1:0], 1'b0};
          end
        end
      end
    end
  end

  logic signed [VW-1:0] x_q [1:N];
  logic signed [VW-1:0] y_q [1:N];
  logic signed [VW-1:0] z_q [1:N];

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [VW-1:0] ATAN = VW'(q62_to_f(atan_q62(i), F));
    logic signed [VW-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = VW'(sr_q[F+1][1]);
      assign yi = VW'(sr_q[F+1][0]);
      assign zi = '0;
    end else begin : g_next
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi >= 0) begin
          x_q[i+1] <= xi + (yi >>> i);
          y_q[i+1] <= yi - (xi >>> i);
          z_q[i+1] <= zi + ATAN;
        end else begin
          x_q[i+1] <= xi - (yi >>> i);
          y_q[i+1] <= yi + (xi >>> i);
          z_q[i+1] <= zi - ATAN;
        end
      end
    end
  end

  // 2*z*R, split into two partial products
  logic [VW-1:0]   z2;
  logic [VW+20:0]  pl_q;
  logic [VW+19:0]  ph_q;
  logic [VW+43:0]  dp;

  always_comb begin
    z2 = z_q[N][VW-1] ? '0 : (VW'(z_q[N]) << 1);
    dp = (VW+44)'(pl_q) + ((VW+44)'(ph_q) << 21) + ((VW+44)'(1) << (F + 7));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= (VW+21)'(z2) * (VW+21)'(R_MM_Q8[20:0]);
      ph_q   <= (VW+20)'(z2) * (VW+20)'(R_MM_Q8[40:21]);
      dist_o <= 35'(dp >> (F + 8));
    end
  end

endmodule
